[hw/rtl/rwd_pkg.sv]
`timescale 1ns / 1ps

package rwd_pkg;

   localparam int WordWidth  = 32;
   localparam int ValueWidth = 30;
   localparam int RowWidth   = 4;
   localparam int FieldWidth = 5;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [RowWidth-1:0]   row_type;
   typedef logic [FieldWidth-1:0] field_type;

   localparam row_type S9LastRow  = 4'd8;
   localparam row_type R10LastRow = 4'd9;
   localparam field_type FullWidth = 5'd30;
   localparam value_type ValueMask = 30'h3FFF_FFFF;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic word_done;
      logic list_done;
   } status_type;

   function automatic field_type s9_count(input row_type row);
      field_type r;
      case (row)
         4'd0:    r = 5'd28;
         4'd1:    r = 5'd14;
         4'd2:    r = 5'd9;
         4'd3:    r = 5'd7;
         4'd4:    r = 5'd5;
         4'd5:    r = 5'd4;
         4'd6:    r = 5'd3;
         4'd7:    r = 5'd2;
         default: r = 5'd1;
      endcase
      return r;
   endfunction

   function automatic field_type s9_bits(input row_type row);
      field_type r;
      case (row)
         4'd0:    r = 5'd1;
         4'd1:    r = 5'd2;
         4'd2:    r = 5'd3;
         4'd3:    r = 5'd4;
         4'd4:    r = 5'd5;
         4'd5:    r = 5'd7;
         4'd6:    r = 5'd9;
         4'd7:    r = 5'd14;
         default: r = 5'd28;
      endcase
      return r;
   endfunction

   function automatic field_type r10_count(input row_type row);
      field_type r;
      case (row)
         4'd0:    r = 5'd30;
         4'd1:    r = 5'd15;
         4'd2:    r = 5'd10;
         4'd3:    r = 5'd7;
         4'd4:    r = 5'd6;
         4'd5:    r = 5'd5;
         4'd6:    r = 5'd4;
         4'd7:    r = 5'd3;
         4'd8:    r = 5'd2;
         default: r = 5'd1;
      endcase
      return r;
   endfunction

   function automatic field_type r10_bits(input row_type row);
      field_type r;
      case (row)
         4'd0:    r = 5'd1;
         4'd1:    r = 5'd2;
         4'd2:    r = 5'd3;
         4'd3:    r = 5'd4;
         4'd4:    r = 5'd5;
         4'd5:    r = 5'd6;
         4'd6:    r = 5'd7;
         4'd7:    r = 5'd10;
         4'd8:    r = 5'd15;
         default: r = 5'd30;
      endcase
      return r;
   endfunction

   // Next row from the previous row and the two selector bits of the word.
   function automatic row_type r10_next(input row_type prev, input logic [1:0] sel);
      row_type r;
      if (sel == 2'd3) begin
         r = R10LastRow;
      end else begin
         case (prev)
            4'd0, 4'd1: r = row_type'(sel);
            4'd7, 4'd8, 4'd9: r = 4'd6 + row_type'(sel);
            default: r = prev - 4'd1 + row_type'(sel);
         endcase
      end
      return r;
   endfunction

endpackage

[hw/rtl/rwd_req_if.sv]
`timescale 1ns / 1ps

interface rwd_req_if;
   logic               valid;
   logic               ready;
   rwd_pkg::word_type  code_word;

   modport source (output valid, output code_word, input ready);
   modport sink (input valid, input code_word, output ready);
endinterface

[hw/rtl/rwd_rsp_if.sv]
`timescale 1ns / 1ps

interface rwd_rsp_if;
   logic               valid;
   logic               ready;
   rwd_pkg::value_type value;
   logic               list_end;
   logic               word_end;

   modport source (output valid, output value, output list_end, output word_end,
                   input ready);
   modport sink (input valid, input value, input list_end, input word_end,
                 output ready);
endinterface

[hw/rtl/rwd_controller.sv]
`timescale 1ns / 1ps

module rwd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rwd_pkg::status_type  status,
   output rwd_pkg::cmd_type     cmd
);
   import rwd_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StEmit = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready   = (state_ff == StIdle);
   assign rsp_valid   = (state_ff == StEmit);
   assign cmd.load    = req_valid && req_ready;
   assign cmd.advance = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (cmd.load) state_in = StEmit;
         end
         StEmit: begin
            if (cmd.advance && status.word_done) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("decoded word produced no item");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status.list_done |-> status.word_done)
      else $error("list ended before the end of its word");
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance && !status.word_done |=> rsp_valid)
      else $error("word left before all its fields were sent");
`endif
endmodule

[hw/rtl/rwd_datapath.sv]
`timescale 1ns / 1ps

module rwd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rwd_pkg::cmd_type     cmd,
   output rwd_pkg::status_type  status,
   input  rwd_pkg::word_type    code_word,
   input  logic                 csr_write_enable,
   input  rwd_pkg::word_type    csr_write_data,
   output rwd_pkg::value_type   value,
   output logic                 list_end,
   output logic                 word_end
);
   import rwd_pkg::*;

   word_type  list_length_ff, list_length_in;
   row_type   current_row_ff, current_row_in;
   word_type  remaining_ff, remaining_in;
   logic      expect_header_ff, expect_header_in;
   value_type payload_ff, payload_in;
   field_type bits_ff, bits_in;
   field_type word_left_ff, word_left_in;

   logic      is_header;
   row_type   s9_row;
   row_type   prev_row;
   row_type   row;
   field_type count;
   field_type width;
   word_type  owed;
   value_type mask;

   assign is_header = expect_header_ff || (remaining_ff == '0);
   assign s9_row    = (code_word[31:28] > S9LastRow) ? S9LastRow : code_word[31:28];
   assign prev_row  = (current_row_ff > R10LastRow) ? R10LastRow : current_row_ff;
   assign row       = is_header ? s9_row : r10_next(prev_row, code_word[31:30]);
   assign count     = is_header ? s9_count(row) : r10_count(row);
   assign width     = is_header ? s9_bits(row) : r10_bits(row);
   assign owed      = is_header ? ((list_length_ff == '0) ? 32'd1 : list_length_ff)
                                : remaining_ff;

   // Field mask built from the all-ones word, so a full-width field needs no wrap.
   assign mask     = ValueMask >> (FullWidth - bits_ff);
   assign value    = payload_ff & mask;
   assign list_end = (remaining_ff == 32'd1);
   assign word_end = (word_left_ff == 5'd1);

   assign status.word_done = word_end;
   assign status.list_done = list_end;

   always_comb begin
      list_length_in   = csr_write_enable ? csr_write_data : list_length_ff;
      current_row_in   = current_row_ff;
      remaining_in     = remaining_ff;
      expect_header_in = expect_header_ff;
      payload_in       = payload_ff;
      bits_in          = bits_ff;
      word_left_in     = word_left_ff;
      if (cmd.load) begin
         current_row_in   = row;
         remaining_in     = owed;
         expect_header_in = 1'b0;
         payload_in       = is_header ? {2'b00, code_word[27:0]} : code_word[29:0];
         bits_in          = width;
         word_left_in     = ({27'd0, count} > owed) ? owed[4:0] : count;
      end else if (cmd.advance) begin
         payload_in   = payload_ff >> bits_ff;
         remaining_in = remaining_ff - 32'd1;
         word_left_in = word_left_ff - 5'd1;
         if (remaining_ff == 32'd1) expect_header_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff   <= 32'd1;
         current_row_ff   <= '0;
         remaining_ff     <= '0;
         expect_header_ff <= 1'b1;
         word_left_ff     <= '0;
      end else begin
         list_length_ff   <= list_length_in;
         current_row_ff   <= current_row_in;
         remaining_ff     <= remaining_in;
         expect_header_ff <= expect_header_in;
         word_left_ff     <= word_left_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      bits_ff    <= bits_in;
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (word_left_ff != '0) && (word_left_ff <= FullWidth))
      else $error("field count of a word out of range");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (remaining_ff != '0) && !expect_header_ff)
      else $error("word decoded with nothing owed");
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance && (remaining_ff == 32'd1) |=> expect_header_ff)
      else $error("list ended without arming a new header");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.advance))
      else $error("load and advance in the same cycle");
`endif
endmodule

[hw/rtl/relative10_word_decoder.sv]
`timescale 1ns / 1ps

// Decodes one posting list of 32-bit compressed words: the first word of a list is a
// Simple-9 header and every later word is Relative-10, with the row chosen from the
// previous row and the top two bits. Fields leave from the low end of the word, one item
// per cycle while the receiver is ready, flagged at the last field of each word and at
// the last integer of the list, after which the next word starts a new list. A word yields
// n fields (1 to 30), set by the single field extractor, which shifts the held word by
// one field per delivered item, and ready is high only between words. list_length is
// sampled when a header word is taken; zero counts as one.
module relative10_word_decoder (
   input  logic               clock,
   input  logic               reset,
   rwd_req_if.sink            req_ch,
   rwd_rsp_if.source          rsp_ch,
   input  logic               csr_write_enable,
   input  rwd_pkg::word_type  csr_write_data
);
   import rwd_pkg::*;

   cmd_type    cmd;
   status_type status;

   rwd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rwd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .code_word        (req_ch.code_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .value            (rsp_ch.value),
      .list_end         (rsp_ch.list_end),
      .word_end         (rsp_ch.word_end)
   );
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import rwd_pkg::*;

   localparam int QuietLimit  = 3000;
   localparam int DrainCycles = 40;
   localparam int PhaseItems  = 19;
   localparam int PhaseCount  = 8;
   localparam int PrintCap    = 200;

   // Field counts and widths per row; element 0 is the rightmost entry.
   localparam logic [8:0][FieldWidth-1:0] S9Count =
      {5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd9, 5'd14, 5'd28};
   localparam logic [8:0][FieldWidth-1:0] S9Width =
      {5'd28, 5'd14, 5'd9, 5'd7, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
   localparam logic [9:0][FieldWidth-1:0] R10Count =
      {5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd15, 5'd30};
   localparam logic [9:0][FieldWidth-1:0] R10Width =
      {5'd30, 5'd15, 5'd10, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};

   typedef struct packed {
      value_type value;
      logic      list_end;
      logic      word_end;
   } decoded_int_type;

   typedef struct {
      logic        set_length;
      logic [31:0] length;
      word_type    word;
      logic        typed;
      value_type   value;
   } directed_row_type;

   logic     clock;
   logic     reset;
   logic     csr_write_enable;
   word_type csr_write_data;

   rwd_req_if req_ch ();
   rwd_rsp_if rsp_ch ();

   relative10_word_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the decoder's state and its length register.
   logic [31:0]      length_reg;
   row_type          last_row;
   logic [31:0]      owed;
   logic             header_next;

   decoded_int_type  owed_ints[$];
   decoded_int_type  due_int;
   directed_row_type directed_rows[$];
   int               error_count;
   int               quiet_cycles;
   int               sender_gap_pct;
   int               receiver_stall_pct;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_failure(input string what);
      if (error_count < PrintCap) begin
         $display("%0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic void decode_word(input word_type w, input logic record);
      int unsigned     row;
      int unsigned     fields;
      int unsigned     width;
      int unsigned     base;
      int unsigned     k;
      logic [31:0]     payload;
      logic [31:0]     mask;
      decoded_int_type d;
      if (header_next || owed == 0) begin
         row = (w[31:28] > 4'd8) ? 8 : w[31:28];
         fields = S9Count[row];
         width = S9Width[row];
         payload = {4'b0000, w[27:0]};
         owed = (length_reg == 0) ? 32'd1 : length_reg;
         header_next = 1'b0;
      end else begin
         // Selector values 0 to 2 pick a window of three rows around the previous
         // row; the top value always jumps to the single 30-bit field.
         base = (last_row == 0) ? 0 : ((last_row > 7) ? 6 : last_row - 1);
         row = (w[31:30] == 2'd3) ? 9 : base + w[31:30];
         fields = R10Count[row];
         width = R10Width[row];
         payload = {2'b00, w[29:0]};
      end
      last_row = row_type'(row);
      if (fields > owed) fields = owed;
      mask = (32'd1 << width) - 32'd1;
      for (k = 0; k < fields; k++) begin
         d.value = value_type'(payload & mask);
         payload = payload >> width;
         owed = owed - 32'd1;
         d.list_end = (owed == 0);
         d.word_end = (k + 1 == fields);
         if (record) owed_ints.push_back(d);
      end
      if (owed == 0) header_next = 1'b1;
   endfunction

   function automatic void add_row(input logic set_len, input logic [31:0] len,
                                   input word_type w, input logic typed,
                                   input value_type v);
      directed_row_type r;
      r.set_length = set_len;
      r.length = len;
      r.word = w;
      r.typed = typed;
      r.value = v;
      directed_rows.push_back(r);
   endfunction

   // Drops valid and holds off until every owed integer has come out.
   task automatic park_sender();
      req_ch.valid <= 1'b0;
      while (owed_ints.size() != 0) @(posedge clock);
   endtask

   task automatic set_length(input logic [31:0] len);
      park_sender();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      length_reg = len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_word(input word_type w, input logic record);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.code_word <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      decode_word(w, record);
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_ints.size() == 0) begin
            report_failure($sformatf("unexpected item, value %0h", rsp_ch.value));
         end else begin
            due_int = owed_ints.pop_front();
            if (rsp_ch.value !== due_int.value)
               report_failure($sformatf("value %0h, wanted %0h",
                                        rsp_ch.value, due_int.value));
            if (rsp_ch.list_end !== due_int.list_end)
               report_failure($sformatf("list_end %b, wanted %b",
                                        rsp_ch.list_end, due_int.list_end));
            if (rsp_ch.word_end !== due_int.word_end)
               report_failure($sformatf("word_end %b, wanted %b",
                                        rsp_ch.word_end, due_int.word_end));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          phase;
      int          item;
      word_type    w;
      logic [31:0] len;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.code_word <= '0;
      length_reg = 32'd1;
      last_row = '0;
      owed = '0;
      header_next = 1'b1;
      error_count = 0;
      sender_gap_pct = 0;
      receiver_stall_pct = 0;

      // Single-integer lists from the reset length, then an oversized selector,
      // a zero length, and longer lists that stop short of and exactly at a word.
      add_row(1'b0, 32'd0, 32'h0000_0001, 1'b1, 30'h1);
      add_row(1'b0, 32'd0, 32'h0000_0000, 1'b1, 30'h0);
      add_row(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 30'h0FFF_FFFF);
      add_row(1'b0, 32'd0, 32'h8FFF_FFFF, 1'b1, 30'h0FFF_FFFF);
      add_row(1'b0, 32'd0, 32'h9000_0000, 1'b1, 30'h0);
      add_row(1'b1, 32'd0, 32'h7000_3FFF, 1'b1, 30'h3FFF);
      add_row(1'b1, 32'd30, 32'h0FFF_FFFF, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h3FFF_FFFF, 1'b0, '0);
      add_row(1'b1, 32'd58, 32'h0AAA_AAAA, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h2AAA_AAAA, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h5123_4567, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h0000_0000, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h4000_0000, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'h8FFF_FFFF, 1'b0, '0);
      add_row(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(1'b1, 32'd3, 32'h6ABC_DEF0, 1'b0, '0);

      fork
         begin
            repeat (7) @(posedge clock);
            reset <= 1'b0;
            foreach (directed_rows[i]) begin
               if (directed_rows[i].set_length) set_length(directed_rows[i].length);
               send_word(directed_rows[i].word, !directed_rows[i].typed);
               if (directed_rows[i].typed)
                  owed_ints.push_back(decoded_int_type'{directed_rows[i].value, 1'b1,
                                                        1'b1});
            end

            for (phase = 0; phase < PhaseCount; phase++) begin
               case (phase % 4)
                  0: begin
                     sender_gap_pct = 0;
                     receiver_stall_pct = 0;
                  end
                  1: begin
                     sender_gap_pct = 50;
                     receiver_stall_pct = 0;
                  end
                  2: begin
                     sender_gap_pct = 0;
                     receiver_stall_pct = 50;
                  end
                  default: begin
                     sender_gap_pct = 8;
                     receiver_stall_pct = 8;
                  end
               endcase
               // The longest length goes last, since a list that long never ends.
               case (phase)
                  0: len = 32'd1;
                  1: len = 32'd0;
                  PhaseCount - 1: len = 32'hFFFF_FFFF;
                  default: begin
                     if ($urandom_range(0, 3) == 0) len = $urandom_range(65, 300);
                     else len = $urandom_range(2, 40);
                  end
               endcase
               set_length(len);
               for (item = 0; item < PhaseItems; item++) begin
                  if (phase == 4 && item == 9) park_sender();
                  w = $urandom;
                  // Most headers use a defined selector; the rest take a random one that may exercise the clamp.
                  if ((header_next || owed == 0) && $urandom_range(0, 3) != 0)
                     w[31:28] = 4'($urandom_range(0, 8));
                  send_word(w, 1'b1);
               end
            end

            park_sender();
            repeat (DrainCycles) @(posedge clock);
         end
         wait (quiet_cycles >= QuietLimit);
      join_any

      if (quiet_cycles >= QuietLimit)
         report_failure("no item moved on either channel for too long");
      if (owed_ints.size() != 0)
         report_failure($sformatf("%0d integers never arrived", owed_ints.size()));
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/rwd_pkg.sv
hw/rtl/rwd_req_if.sv
hw/rtl/rwd_rsp_if.sv
hw/rtl/rwd_controller.sv
hw/rtl/rwd_datapath.sv
hw/rtl/relative10_word_decoder.sv
tb/sv/testbench.sv
